FILE: rtl/core/rvr_pkg.sv
package rvr_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int FRACTION_BITS   = 14;

    localparam int ADDR_WIDTH = 4;
    localparam int DATA_WIDTH = 32;

    localparam logic [1:0] REG_ROTOR_W = 2'd0;
    localparam logic [1:0] REG_ROTOR_X = 2'd1;
    localparam logic [1:0] REG_ROTOR_Y = 2'd2;
    localparam logic [1:0] REG_ROTOR_Z = 2'd3;

    typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;

    typedef struct packed {
        comp_t vec_x;
        comp_t vec_y;
        comp_t vec_z;
    } vec_item_t;

    typedef struct packed {
        comp_t out_x;
        comp_t out_y;
        comp_t out_z;
        logic  saturated;
    } res_item_t;

endpackage

FILE: rtl/core/rotor_vector_rotation.sv
// rotor_vector_rotation: rotates a stream of 3-d vectors by a quaternion rotor.
// the rotor (w, x, y, z, signed fixed point with FRACTION_BITS fraction bits)
// sits in four registers at byte addresses 0, 4, 8 and 12 of the apb port;
// write them only while no item is in flight.
// input channel: vec_valid / vec_stall / vec carry one vector per item.
// output channel: res_valid / res_stall / res carry the rotated vector,
// rounded to nearest and saturated, with a flag when any component clipped.
// one item per cycle is sustained while the receiver does not stall; the
// five register stages (products, first sums, second products, final sums,
// round and saturate) advance together.
// when the receiver stalls with a result waiting, the whole pipeline holds
// and vec_stall is raised in the same cycle; nothing is dropped or repeated.
// reset empties the pipeline and loads the identity rotor (w = 1.0).
// a non-unit rotor scales the result by the squared rotor norm.
module rotor_vector_rotation #(
    parameter int FRACTION_BITS = rvr_pkg::FRACTION_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              vec_valid,
    output logic                              vec_stall,
    input  rvr_pkg::vec_item_t                vec,
    output logic                              res_valid,
    input  logic                              res_stall,
    output rvr_pkg::res_item_t                res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rvr_pkg::ADDR_WIDTH-1:0]    paddr,
    input  logic [rvr_pkg::DATA_WIDTH-1:0]    pwdata,
    output logic [rvr_pkg::DATA_WIDTH-1:0]    prdata,
    output logic                              pready
);

    localparam int CW     = rvr_pkg::COMPONENT_WIDTH;
    localparam int PW     = 2 * CW;
    localparam int TW     = PW + 2;
    localparam int QW     = TW + CW;
    localparam int SW     = QW + 2;
    localparam int STAGES = 5;
    localparam logic [31:0] ONE_FIX = 32'd1 << FRACTION_BITS;
    localparam logic [CW-1:0] W_RESET = ONE_FIX[CW-1:0];

    rvr_pkg::comp_t rw_reg;
    rvr_pkg::comp_t rx_reg;
    rvr_pkg::comp_t ry_reg;
    rvr_pkg::comp_t rz_reg;

    logic                 cfg_write;
    logic [1:0]           cfg_index;
    logic [STAGES-1:0]    valid_reg;
    logic [STAGES-1:0]    valid_next;
    logic                 advance;
    logic                 accept;

    logic signed [PW-1:0] p_reg [12];
    logic signed [PW-1:0] p_next [12];
    logic signed [TW-1:0] t_reg [4];
    logic signed [TW-1:0] t_next [4];
    logic signed [QW-1:0] q_reg [12];
    logic signed [QW-1:0] q_next [12];
    logic signed [SW-1:0] o_reg [3];
    logic signed [SW-1:0] o_next [3];

    rvr_pkg::comp_t       rnd_val [3];
    logic [2:0]           rnd_clip;
    rvr_pkg::res_item_t   res_reg;
    rvr_pkg::res_item_t   res_next;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rw_reg <= W_RESET;
            rx_reg <= '0;
            ry_reg <= '0;
            rz_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rvr_pkg::REG_ROTOR_W: rw_reg <= pwdata[CW-1:0];
                rvr_pkg::REG_ROTOR_X: rx_reg <= pwdata[CW-1:0];
                rvr_pkg::REG_ROTOR_Y: ry_reg <= pwdata[CW-1:0];
                rvr_pkg::REG_ROTOR_Z: rz_reg <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            rvr_pkg::REG_ROTOR_W: prdata = {{(rvr_pkg::DATA_WIDTH-CW){1'b0}}, rw_reg};
            rvr_pkg::REG_ROTOR_X: prdata = {{(rvr_pkg::DATA_WIDTH-CW){1'b0}}, rx_reg};
            rvr_pkg::REG_ROTOR_Y: prdata = {{(rvr_pkg::DATA_WIDTH-CW){1'b0}}, ry_reg};
            rvr_pkg::REG_ROTOR_Z: prdata = {{(rvr_pkg::DATA_WIDTH-CW){1'b0}}, rz_reg};
            default:              prdata = '0;
        endcase
    end

    // pipeline control
    assign advance    = !(valid_reg[STAGES-1] && res_stall);
    assign vec_stall  = valid_reg[STAGES-1] && res_stall;
    assign accept     = vec_valid && !vec_stall;
    assign valid_next = {valid_reg[STAGES-2:0], vec_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    // stage 1: r * v products
    always_comb
    begin
        p_next[0]  = rx_reg * vec.vec_x;
        p_next[1]  = ry_reg * vec.vec_y;
        p_next[2]  = rz_reg * vec.vec_z;
        p_next[3]  = rw_reg * vec.vec_x;
        p_next[4]  = ry_reg * vec.vec_z;
        p_next[5]  = rz_reg * vec.vec_y;
        p_next[6]  = rw_reg * vec.vec_y;
        p_next[7]  = rz_reg * vec.vec_x;
        p_next[8]  = rx_reg * vec.vec_z;
        p_next[9]  = rw_reg * vec.vec_z;
        p_next[10] = rx_reg * vec.vec_y;
        p_next[11] = ry_reg * vec.vec_x;
    end

    // stage 2: t = r * v
    always_comb
    begin
        t_next[0] = -(TW'(p_reg[0]) + TW'(p_reg[1]) + TW'(p_reg[2]));
        t_next[1] = TW'(p_reg[3]) + TW'(p_reg[4]) - TW'(p_reg[5]);
        t_next[2] = TW'(p_reg[6]) + TW'(p_reg[7]) - TW'(p_reg[8]);
        t_next[3] = TW'(p_reg[9]) + TW'(p_reg[10]) - TW'(p_reg[11]);
    end

    // stage 3: t * conj(r) products
    always_comb
    begin
        q_next[0]  = t_reg[1] * rw_reg;
        q_next[1]  = t_reg[0] * rx_reg;
        q_next[2]  = t_reg[2] * rz_reg;
        q_next[3]  = t_reg[3] * ry_reg;
        q_next[4]  = t_reg[2] * rw_reg;
        q_next[5]  = t_reg[0] * ry_reg;
        q_next[6]  = t_reg[3] * rx_reg;
        q_next[7]  = t_reg[1] * rz_reg;
        q_next[8]  = t_reg[3] * rw_reg;
        q_next[9]  = t_reg[0] * rz_reg;
        q_next[10] = t_reg[1] * ry_reg;
        q_next[11] = t_reg[2] * rx_reg;
    end

    // stage 4: vector part sums
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            o_next[i] = SW'(q_reg[4*i]) - SW'(q_reg[4*i+1])
                      - SW'(q_reg[4*i+2]) + SW'(q_reg[4*i+3]);
        end
    end

    // stage 5: round, shift and saturate
    for (genvar g = 0; g < 3; g++)
    begin : g_round
        rvr_round #(
            .IN_WIDTH  (SW),
            .DROP_BITS (2 * FRACTION_BITS)
        ) u_round (
            .value   (o_reg[g]),
            .result  (rnd_val[g]),
            .clipped (rnd_clip[g])
        );
    end

    always_comb
    begin
        res_next.out_x     = rnd_val[0];
        res_next.out_y     = rnd_val[1];
        res_next.out_z     = rnd_val[2];
        res_next.saturated = |rnd_clip;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_reg   <= p_next;
            t_reg   <= t_next;
            q_reg   <= q_next;
            o_reg   <= o_next;
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg[STAGES-1];
    assign res       = res_reg;

    // checks
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        vec_stall |-> (res_valid && res_stall))
        else $error("input stalled without a waiting result");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept ##1 !res_stall ##1 !res_stall ##1 !res_stall ##1 !res_stall
        |=> res_valid)
        else $error("accepted item did not reach the output");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.saturated) |->
        (res.out_x == {1'b1, {(CW-1){1'b0}}} || res.out_x == {1'b0, {(CW-1){1'b1}}} ||
         res.out_y == {1'b1, {(CW-1){1'b0}}} || res.out_y == {1'b0, {(CW-1){1'b1}}} ||
         res.out_z == {1'b1, {(CW-1){1'b0}}} || res.out_z == {1'b0, {(CW-1){1'b1}}}))
        else $error("saturated flag without a clipped component");

endmodule

FILE: rtl/core/rvr_round.sv
module rvr_round #(
    parameter int IN_WIDTH  = 52,
    parameter int DROP_BITS = 28
) (
    input  logic signed [IN_WIDTH-1:0]  value,
    output rvr_pkg::comp_t              result,
    output logic                        clipped
);

    localparam int CW = rvr_pkg::COMPONENT_WIDTH;
    localparam int RW = (IN_WIDTH > DROP_BITS) ? IN_WIDTH + 1 : DROP_BITS + 2;
    localparam logic [RW-1:0] HALF = {{(RW-1){1'b0}}, 1'b1} << (DROP_BITS - 1);
    localparam logic [CW-1:0] MAX_VAL = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MIN_VAL = {1'b1, {(CW-1){1'b0}}};

    logic signed [RW-1:0] ext;
    logic signed [RW-1:0] rounded;
    logic signed [RW-1:0] shifted;
    logic                 fits;

    always_comb
    begin
        ext     = RW'(value);
        rounded = ext + $signed(HALF);
        shifted = rounded >>> DROP_BITS;
        fits    = (&shifted[RW-1:CW-1]) || !(|shifted[RW-1:CW-1]);
        clipped = !fits;
        if (fits)
        begin
            result = shifted[CW-1:0];
        end
        else if (rounded[RW-1])
        begin
            result = MIN_VAL;
        end
        else
        begin
            result = MAX_VAL;
        end
    end

endmodule
